// ----- rtl/mrtt_pkg.sv -----
// mrtt_pkg: shared sizes, codes and types of the region translation table
// used by mrtt_cell, mrtt_chain and memory_region_translation_table_unit
// no dependencies
package mrtt_pkg;

   localparam int REGIONS   = 8;
   localparam int PAGE_BITS = 12;

   localparam int OPCODE_W = 3;
   localparam int PHYS_W   = 40;
   localparam int VIRT_W   = 32;
   localparam int LEN_W    = 32;
   localparam int FRAME_W  = 28;
   localparam int FCOUNT_W = 29;
   localparam int STATUS_W = 2;

   localparam int VPAGE_W = VIRT_W - PAGE_BITS;
   localparam int PPAGE_W = PHYS_W - PAGE_BITS;
   localparam int NPG_W   = LEN_W - PAGE_BITS;
   localparam int VEXT_W  = VPAGE_W + 1;
   localparam int FW      = ((PPAGE_W > FRAME_W) ? PPAGE_W : FRAME_W) + 1;
   localparam int CNT_W   = $clog2(REGIONS + 1);
   localparam int IDX_W   = (REGIONS > 1) ? $clog2(REGIONS) : 1;

   localparam logic [OPCODE_W-1:0] OP_REGISTER      = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_FRAME_VALID   = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_RANGE_VALID   = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_FRAME_TO_VIRT = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_VIRT_TO_FRAME = 3'd4;

   localparam logic [STATUS_W-1:0] STS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STS_MISALIGNED = 2'd1;
   localparam logic [STATUS_W-1:0] STS_FULL       = 2'd2;
   localparam logic [STATUS_W-1:0] STS_OVERLAP    = 2'd3;

   // one stored region, kept in pages
   typedef struct packed {
      logic [VPAGE_W-1:0] vp;
      logic [PPAGE_W-1:0] pp;
      logic [NPG_W-1:0]   n;
   } region_type;

   // query word that walks the cell row
   typedef struct packed {
      logic               live;
      logic [CNT_W-1:0]   rem;
      logic [FW-1:0]      f;
      logic [VPAGE_W-1:0] qvp;
      logic [NPG_W-1:0]   cn;
      logic               fhit;
      logic [NPG_W-1:0]   left;
      logic [VPAGE_W-1:0] vres;
      logic               vhit;
      logic [FRAME_W-1:0] fres;
      logic               ovl;
   } token_type;

endpackage

// ----- rtl/mrtt_cell.sv -----
// mrtt_cell: one table entry and its compare logic, passes the query word on
// depends on mrtt_pkg
module mrtt_cell import mrtt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  token_type  tok_i,
   output token_type  tok_o,
   input  logic       wr_en,
   input  region_type wr_region
);

   region_type         region_ff;
   token_type          tok_ff;
   token_type          tok_in;
   logic               active;
   logic [FW-1:0]      f_diff;
   logic               f_match;
   logic [VPAGE_W-1:0] v_diff;
   logic               v_match;
   logic               v_ovl;
   logic               p_ovl;

   always_comb begin
      active  = tok_i.live && (tok_i.rem != '0);
      f_diff  = tok_i.f - FW'(region_ff.pp);
      f_match = (tok_i.f >= FW'(region_ff.pp)) && (f_diff < FW'(region_ff.n));
      v_diff  = tok_i.qvp - region_ff.vp;
      v_match = (tok_i.qvp >= region_ff.vp) && (NPG_W'(v_diff) < region_ff.n);
      v_ovl   = (VEXT_W'(tok_i.qvp) < VEXT_W'(region_ff.vp) + VEXT_W'(region_ff.n)) &&
                (VEXT_W'(region_ff.vp) < VEXT_W'(tok_i.qvp) + VEXT_W'(tok_i.cn));
      p_ovl   = (tok_i.f < FW'(region_ff.pp) + FW'(region_ff.n)) &&
                (FW'(region_ff.pp) < tok_i.f + FW'(tok_i.cn));
      tok_in = tok_i;
      if (active) begin
         tok_in.rem = tok_i.rem - CNT_W'(1);
         if (!tok_i.fhit && f_match) begin
            tok_in.fhit = 1'b1;
            tok_in.left = region_ff.n - NPG_W'(f_diff);
            tok_in.vres = region_ff.vp + VPAGE_W'(f_diff);
         end
         if (!tok_i.vhit && v_match) begin
            tok_in.vhit = 1'b1;
            tok_in.fres = FRAME_W'(FW'(region_ff.pp) + FW'(v_diff));
         end
         if (v_ovl || p_ovl) begin
            tok_in.ovl = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.live <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         region_ff <= wr_region;
      end
   end

   assign tok_o = tok_ff;

endmodule

// ----- rtl/mrtt_chain.sv -----
// mrtt_chain: row of table cells with write select decode
// depends on mrtt_pkg and mrtt_cell
module mrtt_chain import mrtt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  token_type        tok_head,
   output token_type        tok_tail,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_index,
   input  region_type       wr_region
);

   token_type          tok_w [REGIONS+1];
   logic [REGIONS-1:0] wr_sel;

   assign tok_w[0] = tok_head;

   for (genvar i = 0; i < REGIONS; i++) begin : g_cell
      assign wr_sel[i] = wr_en && (wr_index == IDX_W'(i));
      mrtt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .tok_i     (tok_w[i]),
         .tok_o     (tok_w[i+1]),
         .wr_en     (wr_sel[i]),
         .wr_region (wr_region)
      );
   end

   assign tok_tail = tok_w[REGIONS];

endmodule

// ----- rtl/memory_region_translation_table_unit.sv -----
// memory_region_translation_table_unit: top level, command sequencer and result register
// depends on mrtt_pkg and mrtt_chain
//
// Each accepted command that needs the table sends one query word down a row
// of REGIONS cells, one cell per cycle, and the result register raises the
// strobe once the word leaves the last cell; busy stays high until that
// strobe. Commands settled without the table (zero length, misaligned, full
// table, validity tests on an empty table, zero frame count, unused opcodes)
// strobe the cycle after accept. A frame range test makes one more pass down
// the row for each region it hops into. Results are held for one cycle only
// and must be taken when rsp_strobe is high.
module memory_region_translation_table_unit import mrtt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [PHYS_W-1:0]   req_phys_base,
   input  logic [VIRT_W-1:0]   req_virt_address,
   input  logic [LEN_W-1:0]    req_region_length,
   input  logic [FRAME_W-1:0]  req_frame_number,
   input  logic [FCOUNT_W-1:0] req_frame_count,
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_is_valid,
   output logic [VIRT_W-1:0]   rsp_virt_result,
   output logic [FRAME_W-1:0]  rsp_frame_result,
   output logic                rsp_frame_found
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic                state_ff, state_in;
   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [FCOUNT_W-1:0] nrem_ff, nrem_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_is_valid_ff, rsp_is_valid_in;
   logic [VIRT_W-1:0]   rsp_virt_result_ff, rsp_virt_result_in;
   logic [FRAME_W-1:0]  rsp_frame_result_ff, rsp_frame_result_in;
   logic                rsp_frame_found_ff, rsp_frame_found_in;

   token_type           tok_head;
   token_type           tok_tail;
   logic                wr_en;
   region_type          wr_region;
   logic                misaligned;
   logic [FCOUNT_W-1:0] left_ext;

   assign misaligned = (req_phys_base[PAGE_BITS-1:0] | req_virt_address[PAGE_BITS-1:0] |
                        req_region_length[PAGE_BITS-1:0]) != '0;
   assign left_ext   = FCOUNT_W'(tok_tail.left);

   assign wr_region.vp = tok_tail.qvp;
   assign wr_region.pp = PPAGE_W'(tok_tail.f);
   assign wr_region.n  = tok_tail.cn;

   always_comb begin
      state_in            = state_ff;
      op_in               = op_ff;
      nrem_in             = nrem_ff;
      count_in            = count_ff;
      rsp_strobe_in       = 1'b0;
      rsp_status_in       = STS_OK;
      rsp_is_valid_in     = 1'b0;
      rsp_virt_result_in  = '0;
      rsp_frame_result_in = '0;
      rsp_frame_found_in  = 1'b0;
      wr_en               = 1'b0;
      tok_head            = '0;
      tok_head.rem        = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            tok_head.qvp = req_virt_address[VIRT_W-1:PAGE_BITS];
            tok_head.cn  = req_region_length[LEN_W-1:PAGE_BITS];
            if (req_opcode == OP_REGISTER) begin
               tok_head.f = FW'(req_phys_base[PHYS_W-1:PAGE_BITS]);
            end else begin
               tok_head.f = FW'(req_frame_number);
            end
            if (start) begin
               op_in   = req_opcode;
               nrem_in = req_frame_count;
               unique case (req_opcode) inside
                  OP_REGISTER: begin
                     if (req_region_length == '0) begin
                        rsp_strobe_in = 1'b1;
                     end else if (misaligned) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STS_MISALIGNED;
                     end else if (count_ff >= CNT_W'(REGIONS)) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STS_FULL;
                     end else begin
                        tok_head.live = 1'b1;
                        state_in      = ST_RUN;
                     end
                  end
                  OP_FRAME_VALID: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in   = 1'b1;
                        rsp_is_valid_in = 1'b1;
                     end else begin
                        tok_head.live = 1'b1;
                        state_in      = ST_RUN;
                     end
                  end
                  OP_RANGE_VALID: begin
                     if (count_ff == '0 || req_frame_count == '0) begin
                        rsp_strobe_in   = 1'b1;
                        rsp_is_valid_in = 1'b1;
                     end else begin
                        tok_head.live = 1'b1;
                        state_in      = ST_RUN;
                     end
                  end
                  OP_FRAME_TO_VIRT, OP_VIRT_TO_FRAME: begin
                     tok_head.live = 1'b1;
                     state_in      = ST_RUN;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_RUN: begin
            if (tok_tail.live) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
               unique case (op_ff) inside
                  OP_REGISTER: begin
                     if (tok_tail.ovl) begin
                        rsp_status_in = STS_OVERLAP;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_FRAME_VALID: begin
                     rsp_is_valid_in = tok_tail.fhit;
                  end
                  OP_RANGE_VALID: begin
                     if (!tok_tail.fhit) begin
                        rsp_is_valid_in = 1'b0;
                     end else if (left_ext >= nrem_ff) begin
                        rsp_is_valid_in = 1'b1;
                     end else begin
                        // hop into the next region
                        rsp_strobe_in = 1'b0;
                        state_in      = ST_RUN;
                        nrem_in       = nrem_ff - left_ext;
                        tok_head.live = 1'b1;
                        tok_head.f    = tok_tail.f + FW'(tok_tail.left);
                        tok_head.qvp  = tok_tail.qvp;
                        tok_head.cn   = tok_tail.cn;
                     end
                  end
                  OP_FRAME_TO_VIRT: begin
                     rsp_is_valid_in = tok_tail.fhit;
                     if (tok_tail.fhit) begin
                        rsp_virt_result_in = {tok_tail.vres, {PAGE_BITS{1'b0}}};
                     end
                  end
                  OP_VIRT_TO_FRAME: begin
                     rsp_frame_found_in = tok_tail.vhit;
                     if (tok_tail.vhit) begin
                        rsp_frame_result_in = tok_tail.fres;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff               <= op_in;
      nrem_ff             <= nrem_in;
      rsp_status_ff       <= rsp_status_in;
      rsp_is_valid_ff     <= rsp_is_valid_in;
      rsp_virt_result_ff  <= rsp_virt_result_in;
      rsp_frame_result_ff <= rsp_frame_result_in;
      rsp_frame_found_ff  <= rsp_frame_found_in;
   end

   mrtt_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .tok_head  (tok_head),
      .tok_tail  (tok_tail),
      .wr_en     (wr_en),
      .wr_index  (count_ff[IDX_W-1:0]),
      .wr_region (wr_region)
   );

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_is_valid     = rsp_is_valid_ff;
   assign rsp_virt_result  = rsp_virt_result_ff;
   assign rsp_frame_result = rsp_frame_result_ff;
   assign rsp_frame_found  = rsp_frame_found_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(REGIONS))
      else $error("region count above table size");

   a_tail_in_run: assert property (@(posedge clock) disable iff (reset)
      tok_tail.live |-> (state_ff == ST_RUN))
      else $error("query word left the row while idle");

   a_count_on_ok: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |->
         (rsp_strobe_ff && (rsp_status_ff == STS_OK)))
      else $error("region count moved without an ok register result");

endmodule
